// File: design/spic_pkg.sv
// shared types, widths, codes and arithmetic helpers for the segment pair classifier
package spic_pkg;

	localparam int COORD_BITS    = 16;
	localparam int TOL_FRAC_BITS = 16;

	localparam int AREA_W = 32;
	localparam int LEN_W  = 16;
	localparam int PTOL_W = 16;
	localparam int LT2_W  = 2 * LEN_W;
	localparam int REL_W  = 3;
	localparam int IDX_W  = 2;
	localparam int CFG_W  = AREA_W;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int COL_W  = DIFF_W + 1;
	localparam int CMP_A  = (SUM_W > AREA_W) ? SUM_W : AREA_W;
	localparam int CMP_W  = (CMP_A > LT2_W) ? CMP_A : LT2_W;
	localparam int LCMP_W = (DIFF_W > LEN_W) ? DIFF_W : LEN_W;
	localparam int FAC_W  = ((TOL_FRAC_BITS > PTOL_W) ? TOL_FRAC_BITS : PTOL_W) + 1;
	localparam int BND_W  = FAC_W + SUM_W + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [SUM_W-1:0]      sum_t;
	typedef logic signed [COL_W-1:0]      col_t;
	typedef logic [REL_W-1:0]             rel_t;

	localparam rel_t REL_DISJOINT  = 3'd0;
	localparam rel_t REL_PARALLEL  = 3'd1;
	localparam rel_t REL_COL_APART = 3'd2;
	localparam rel_t REL_INTERSECT = 3'd3;
	localparam rel_t REL_OVERLAP   = 3'd4;

	localparam logic [IDX_W-1:0] REG_AREA_TOL   = 2'd0;
	localparam logic [IDX_W-1:0] REG_LENGTH_TOL = 2'd1;
	localparam logic [IDX_W-1:0] REG_PARAM_TOL  = 2'd2;

	function automatic diff_t sub_c(input coord_t a, input coord_t b);
		return DIFF_W'(a) - DIFF_W'(b);
	endfunction

	function automatic prod_t mul_d(input diff_t a, input diff_t b);
		return PROD_W'(a) * PROD_W'(b);
	endfunction

	// magnitude of a sum, widened for compare against the tolerances
	function automatic logic [CMP_W-1:0] mag_s(input sum_t x);
		logic [SUM_W-1:0] m;
		m = x[SUM_W-1] ? SUM_W'(-x) : SUM_W'(x);
		return CMP_W'(m);
	endfunction

	// inclusive span test of q between lo and hi in either order
	function automatic logic between(input coord_t lo, input coord_t hi, input coord_t q);
		return (q >= lo && hi >= q) || (lo >= q && q >= hi);
	endfunction

endpackage

// File: design/spic_if.sv
// handshake channels for segment pair words and relation words
interface spic_in_if;
	import spic_pkg::*;
	logic   valid;
	logic   ready;
	coord_t a_start_x;
	coord_t a_start_y;
	coord_t a_end_x;
	coord_t a_end_y;
	coord_t b_start_x;
	coord_t b_start_y;
	coord_t b_end_x;
	coord_t b_end_y;
	modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, input ready);
	modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface spic_out_if;
	import spic_pkg::*;
	logic valid;
	logic ready;
	rel_t relation;
	modport source (output valid, relation, input ready);
	modport sink (input valid, relation, output ready);
endinterface

// File: design/segment_pair_intersection_classify_unit.sv
// segment pair intersection classifier, six stage pipeline top level
//
//  channel   dir  handshake        payload
//  pairs     in   valid/ready      eight signed coordinates, two segments
//  result    out  valid/ready      relation code
//  wr_*      in   wr_en only       register index and data, no read-back
//
// one word enters per cycle while the pipe advances; from accept to result each word
// passes the stage chain in order: differences, products, sums,
// classification, bound multiply, window compare into the output register
// the whole pipe advances together whenever the output register is empty or taken
// a stall freezes every stage, so no word is lost or repeated
// arst_n clears the stage valid bits and the tolerance registers to zero
module segment_pair_intersection_classify_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	spic_in_if.sink                   pairs,
	spic_out_if.source                result,
	input  logic                      wr_en,
	input  logic [spic_pkg::IDX_W-1:0] wr_index,
	input  logic [spic_pkg::CFG_W-1:0] wr_data
);
	import spic_pkg::*;

	// tolerance registers
	logic [AREA_W-1:0] area_tol_q;
	logic [LEN_W-1:0]  length_tol_q;
	logic [PTOL_W-1:0] param_tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_tol_q   <= '0;
			length_tol_q <= '0;
			param_tol_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_AREA_TOL:   area_tol_q   <= wr_data[AREA_W-1:0];
				REG_LENGTH_TOL: length_tol_q <= wr_data[LEN_W-1:0];
				REG_PARAM_TOL:  param_tol_q  <= wr_data[PTOL_W-1:0];
				default: ;
			endcase
		end
	end

	// one enable for the whole pipe
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign adv          = !v_s6 || result.ready;
	assign pairs.ready  = adv;
	assign result.valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else if (adv) begin
			v_s1 <= pairs.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stage 1: endpoints and edge differences
	coord_t as_x_s1, as_y_s1, ae_x_s1, ae_y_s1, bs_x_s1, bs_y_s1, be_x_s1, be_y_s1;
	diff_t  ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1, w2x_s1, w2y_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			as_x_s1 <= pairs.a_start_x;
			as_y_s1 <= pairs.a_start_y;
			ae_x_s1 <= pairs.a_end_x;
			ae_y_s1 <= pairs.a_end_y;
			bs_x_s1 <= pairs.b_start_x;
			bs_y_s1 <= pairs.b_start_y;
			be_x_s1 <= pairs.b_end_x;
			be_y_s1 <= pairs.b_end_y;
			ux_s1   <= sub_c(pairs.a_end_x, pairs.a_start_x);
			uy_s1   <= sub_c(pairs.a_end_y, pairs.a_start_y);
			vx_s1   <= sub_c(pairs.b_end_x, pairs.b_start_x);
			vy_s1   <= sub_c(pairs.b_end_y, pairs.b_start_y);
			wx_s1   <= sub_c(pairs.a_start_x, pairs.b_start_x);
			wy_s1   <= sub_c(pairs.a_start_y, pairs.b_start_y);
			w2x_s1  <= sub_c(pairs.a_end_x, pairs.b_start_x);
			w2y_s1  <= sub_c(pairs.a_end_y, pairs.b_start_y);
		end
	end

	// stage 2 logic: collinear axis pick, sign normalize and sort of A's ends along B
	logic [DIFF_W-1:0] vx_mag;
	logic              use_x;
	col_t              den_r, n0_r, n1_r, den_n, n0_n, n1_n;
	logic              span_a, span_b;

	always_comb begin
		vx_mag = vx_s1[DIFF_W-1] ? DIFF_W'(-vx_s1) : DIFF_W'(vx_s1);
		use_x  = (LCMP_W'(vx_mag) > LCMP_W'(length_tol_q)) || (vy_s1 == '0);
		den_r  = use_x ? COL_W'(vx_s1) : COL_W'(vy_s1);
		n0_r   = use_x ? COL_W'(wx_s1) : COL_W'(wy_s1);
		n1_r   = use_x ? COL_W'(w2x_s1) : COL_W'(w2y_s1);
		if (den_r < 0) begin
			den_r = -den_r;
			n0_r  = -n0_r;
			n1_r  = -n1_r;
		end
		den_n = den_r;
		if (n1_r < n0_r) begin
			n0_n = n1_r;
			n1_n = n0_r;
		end else begin
			n0_n = n0_r;
			n1_n = n1_r;
		end
		// point-like A: its start against B, on x unless B is vertical
		span_b = (bs_x_s1 != be_x_s1) ? between(bs_x_s1, be_x_s1, as_x_s1)
			: between(bs_y_s1, be_y_s1, as_y_s1);
		// point-like B: its start against A
		span_a = (as_x_s1 != ae_x_s1) ? between(as_x_s1, ae_x_s1, bs_x_s1)
			: between(as_y_s1, ae_y_s1, bs_y_s1);
	end

	// stage 2: all products
	prod_t uxvy_s2, uyvx_s2, uxwy_s2, uywx_s2, vxwy_s2, vywx_s2;
	prod_t uxux_s2, uyuy_s2, vxvx_s2, vyvy_s2, wxwx_s2, wywy_s2;
	logic [LT2_W-1:0] lt2_s2;
	col_t den_s2, n0_s2, n1_s2;
	logic span_a_s2, span_b_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			uxvy_s2   <= mul_d(ux_s1, vy_s1);
			uyvx_s2   <= mul_d(uy_s1, vx_s1);
			uxwy_s2   <= mul_d(ux_s1, wy_s1);
			uywx_s2   <= mul_d(uy_s1, wx_s1);
			vxwy_s2   <= mul_d(vx_s1, wy_s1);
			vywx_s2   <= mul_d(vy_s1, wx_s1);
			uxux_s2   <= mul_d(ux_s1, ux_s1);
			uyuy_s2   <= mul_d(uy_s1, uy_s1);
			vxvx_s2   <= mul_d(vx_s1, vx_s1);
			vyvy_s2   <= mul_d(vy_s1, vy_s1);
			wxwx_s2   <= mul_d(wx_s1, wx_s1);
			wywy_s2   <= mul_d(wy_s1, wy_s1);
			lt2_s2    <= LT2_W'(length_tol_q) * LT2_W'(length_tol_q);
			den_s2    <= den_n;
			n0_s2     <= n0_n;
			n1_s2     <= n1_n;
			span_a_s2 <= span_a;
			span_b_s2 <= span_b;
		end
	end

	// stage 3 logic: collinear overlap decision from the sorted parameters
	rel_t col_rel;
	col_t col_lo, col_hi;
	sum_t dd_sum;

	always_comb begin
		col_lo = (n0_s2 < 0) ? '0 : n0_s2;
		col_hi = (den_s2 < n1_s2) ? den_s2 : n1_s2;
		if (den_s2 < n0_s2 || n1_s2 < 0) begin
			col_rel = REL_COL_APART;
		end else if (col_lo == col_hi) begin
			col_rel = REL_INTERSECT;
		end else begin
			col_rel = REL_OVERLAP;
		end
		dd_sum = SUM_W'(wxwx_s2) + SUM_W'(wywy_s2);
	end

	// stage 3: perp products, squared lengths, near-point flag
	sum_t d_s3, upw_s3, vpw_s3, du_s3, dv_s3;
	logic dd_small_s3;
	rel_t col_rel_s3;
	logic span_a_s3, span_b_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s3        <= SUM_W'(uxvy_s2) - SUM_W'(uyvx_s2);
			upw_s3      <= SUM_W'(uxwy_s2) - SUM_W'(uywx_s2);
			vpw_s3      <= SUM_W'(vxwy_s2) - SUM_W'(vywx_s2);
			du_s3       <= SUM_W'(uxux_s2) + SUM_W'(uyuy_s2);
			dv_s3       <= SUM_W'(vxvx_s2) + SUM_W'(vyvy_s2);
			dd_small_s3 <= CMP_W'(dd_sum) <= CMP_W'(lt2_s2);
			col_rel_s3  <= col_rel;
			span_a_s3   <= span_a_s2;
			span_b_s3   <= span_b_s2;
		end
	end

	// stage 4 logic: classify the non-skew cases, normalize the skew numerators
	logic [CMP_W-1:0] at_w;
	logic             near, du_small, dv_small;
	rel_t             rel_ns;
	logic [SUM_W-1:0] dabs;
	sum_t             sn, tn;

	always_comb begin
		at_w     = CMP_W'(area_tol_q);
		near     = mag_s(d_s3) <= at_w;
		du_small = CMP_W'(du_s3) <= at_w;
		dv_small = CMP_W'(dv_s3) <= at_w;
		if (mag_s(upw_s3) > at_w || mag_s(vpw_s3) > at_w) begin
			rel_ns = REL_PARALLEL;
		end else if (du_small && dv_small) begin
			rel_ns = dd_small_s3 ? REL_INTERSECT : REL_COL_APART;
		end else if (du_small) begin
			rel_ns = span_b_s3 ? REL_INTERSECT : REL_COL_APART;
		end else if (dv_small) begin
			rel_ns = span_a_s3 ? REL_INTERSECT : REL_COL_APART;
		end else begin
			rel_ns = col_rel_s3;
		end
		if (d_s3 < 0) begin
			dabs = SUM_W'(-d_s3);
			sn   = -vpw_s3;
			tn   = -upw_s3;
		end else begin
			dabs = SUM_W'(d_s3);
			sn   = vpw_s3;
			tn   = upw_s3;
		end
	end

	// stage 4
	logic             near_s4;
	rel_t             rel_ns_s4;
	logic [SUM_W-1:0] dabs_s4;
	sum_t             sn_s4, tn_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			near_s4   <= near;
			rel_ns_s4 <= rel_ns;
			dabs_s4   <= dabs;
			sn_s4     <= sn;
			tn_s4     <= tn;
		end
	end

	// stage 5: window bounds, param_tol*|d| and (1+param_tol)*|d| in fixed point
	logic [FAC_W-1:0]   fac_hi;
	logic [BND_W-2:0]   lo_s5, hi_s5;
	logic               near_s5;
	rel_t               rel_ns_s5;
	sum_t               sn_s5, tn_s5;

	assign fac_hi = (FAC_W'(1) << TOL_FRAC_BITS) + FAC_W'(param_tol_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s5     <= (BND_W-1)'(param_tol_q) * (BND_W-1)'(dabs_s4);
			hi_s5     <= (BND_W-1)'(fac_hi) * (BND_W-1)'(dabs_s4);
			near_s5   <= near_s4;
			rel_ns_s5 <= rel_ns_s4;
			sn_s5     <= sn_s4;
			tn_s5     <= tn_s4;
		end
	end

	// stage 6 logic: both scaled numerators inside the slack window
	logic signed [BND_W-1:0] lo_b, hi_b, s_sc, t_sc;
	logic                    skew_hit;

	always_comb begin
		lo_b     = -$signed({1'b0, lo_s5});
		hi_b     = $signed({1'b0, hi_s5});
		s_sc     = BND_W'(sn_s5) <<< TOL_FRAC_BITS;
		t_sc     = BND_W'(tn_s5) <<< TOL_FRAC_BITS;
		skew_hit = (s_sc >= lo_b) && (s_sc <= hi_b) && (t_sc >= lo_b) && (t_sc <= hi_b);
	end

	// stage 6 is the output register
	rel_t relation_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			relation_s6 <= near_s5 ? rel_ns_s5 : (skew_hit ? REL_INTERSECT : REL_DISJOINT);
		end
	end

	assign result.relation = relation_s6;

	// checks
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.relation <= REL_OVERLAP))
		else $error("relation code out of range");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pairs.valid && pairs.ready) |=> v_s1)
		else $error("accepted word missing from first stage");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6}))
		else $error("pipeline moved during stall");

	a_parallel_near: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !near_s5 && adv) |=> (result.relation == REL_DISJOINT
			|| result.relation == REL_INTERSECT))
		else $error("skew pair gave a non-skew relation");

endmodule
